// ===== rtl/core/rpn_stack_calculator_macros.svh =====
// ----------------------------------------------------------------------------
// RPN calculator assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// same-cycle implication
`define RPN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Opcodes, status codes, sequencer states and ALU request type.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  typedef enum logic [3:0] {
    FN_PUSH   = 4'd0,
    FN_ADD    = 4'd1,
    FN_SUB    = 4'd2,
    FN_MUL    = 4'd3,
    FN_DIV    = 4'd4,
    FN_SQUARE = 4'd5,
    FN_NEGATE = 4'd6,
    FN_CLEAR  = 4'd7,
    FN_POP    = 4'd8
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_NXT,
    S_EXEC,
    S_ALU,
    S_WB
  } state_t;

  typedef struct packed {
    logic start;
    logic div;
  } alu_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpn_if.sv =====
// ----------------------------------------------------------------------------
// RPN calculator channels
// Command channel (opcode + operand) and response channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpn_cmd_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [3:0]            func;
  logic [DATA_WIDTH-1:0] operand;

  modport source (output valid, output func, output operand, input ready);
  modport sink   (input valid, input func, input operand, output ready);
endinterface

interface rpn_rsp_if #(
  parameter int DATA_WIDTH  = 32,
  parameter int DEPTH_WIDTH = 7
);
  logic                   valid;
  logic                   ready;
  logic [DATA_WIDTH-1:0]  value;
  logic                   empty_res;
  logic [DEPTH_WIDTH-1:0] depth;
  logic [1:0]             status;

  modport source (output valid, output value, output empty_res, output depth,
                  output status, input ready);
  modport sink   (input valid, input value, input empty_res, input depth,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish calculator on a stack of signed integers held in memory.
// ----------------------------------------------------------------------------
// Each command item carries an opcode and, for push, an operand, and yields
// exactly one response item with the resulting top of stack (or the popped
// value), an empty flag, the depth and a status code. The stack lives in a
// single-port-read synchronous RAM; every command reads the top two entries
// in turn, then writes back at most one entry. Mul, square and div run on
// the shared ALU, which retires one bit per cycle. A response waiting on
// the output register does not block the next command from being accepted.
// The RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input logic     clk,
  input logic     rst,
  rpn_cmd_if.sink cmd,
  rpn_rsp_if.source rsp
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  rpn_pkg::state_t state, state_next;

  logic [DW-1:0]         sp;
  logic [3:0]            func_q;
  logic [DATA_WIDTH-1:0] opnd_q;
  logic [DATA_WIDTH-1:0] r_q;
  logic [DATA_WIDTH-1:0] l_q;

  logic                  wr_q;
  logic [AW-1:0]         waddr_q;
  logic [DW-1:0]         nsp_q;
  logic [DATA_WIDTH-1:0] res_q;
  rpn_pkg::status_t      status_q;

  logic                  out_valid;
  logic [DATA_WIDTH-1:0] out_value;
  logic [DW-1:0]         out_depth;
  rpn_pkg::status_t      out_status;

  logic [DW-1:0]         sp_m1;
  logic [DW-1:0]         sp_m2;
  logic                  wb_go;

  // memory and ALU hookup
  logic                  mem_we;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  rpn_pkg::alu_req_t     alu_req;
  logic [DATA_WIDTH-1:0] alu_a;
  logic [DATA_WIDTH-1:0] alu_b;
  logic                  alu_done;
  logic [DATA_WIDTH-1:0] alu_result;

  // execute decode
  logic                  ex_wr;
  logic [AW-1:0]         ex_addr;
  logic [DW-1:0]         ex_sp;
  logic [DATA_WIDTH-1:0] ex_res;
  rpn_pkg::status_t      ex_status;
  logic                  ex_alu;
  logic                  ex_div;

  assign sp_m1 = sp - DW'(1);
  assign sp_m2 = sp - DW'(2);
  assign wb_go = (state == rpn_pkg::S_WB) && (!out_valid || rsp.ready);

  rpn_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr_q),
    .wdata (res_q),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rpn_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (alu_a),
    .b      (alu_b),
    .done   (alu_done),
    .result (alu_result)
  );

  // what the command does to the stack, from the two operands read
  always_comb begin
    ex_wr     = 1'b0;
    ex_addr   = sp_m1[AW-1:0];
    ex_sp     = sp;
    ex_res    = r_q;
    ex_status = rpn_pkg::ST_OK;
    ex_alu    = 1'b0;
    ex_div    = 1'b0;
    alu_a     = l_q;
    alu_b     = r_q;
    case (func_q)
      rpn_pkg::FN_PUSH: begin
        if (sp == DW'(STACK_DEPTH)) begin
          ex_status = rpn_pkg::ST_OVER;
        end else begin
          ex_wr   = 1'b1;
          ex_addr = sp[AW-1:0];
          ex_sp   = sp + DW'(1);
          ex_res  = opnd_q;
        end
      end
      rpn_pkg::FN_ADD, rpn_pkg::FN_SUB, rpn_pkg::FN_MUL, rpn_pkg::FN_DIV: begin
        if (sp < DW'(2)) begin
          // lone element is dropped
          ex_status = rpn_pkg::ST_UNDER;
          ex_sp     = '0;
          ex_res    = '0;
        end else begin
          ex_wr   = 1'b1;
          ex_addr = sp_m2[AW-1:0];
          ex_sp   = sp_m1;
          case (func_q)
            rpn_pkg::FN_ADD: ex_res = l_q + r_q;
            rpn_pkg::FN_SUB: ex_res = l_q - r_q;
            rpn_pkg::FN_MUL: ex_alu = 1'b1;
            default: begin
              if (r_q == '0) begin
                ex_res    = '0;
                ex_status = rpn_pkg::ST_DIVZ;
              end else begin
                ex_alu = 1'b1;
                ex_div = 1'b1;
              end
            end
          endcase
        end
      end
      rpn_pkg::FN_SQUARE, rpn_pkg::FN_NEGATE: begin
        if (sp == '0) begin
          ex_status = rpn_pkg::ST_UNDER;
        end else begin
          ex_wr = 1'b1;
          alu_a = r_q;
          if (func_q == rpn_pkg::FN_SQUARE) begin
            ex_alu = 1'b1;
          end else begin
            ex_res = ~r_q + 1'b1;
          end
        end
      end
      rpn_pkg::FN_CLEAR: begin
        ex_sp  = '0;
        ex_res = '0;
      end
      rpn_pkg::FN_POP: begin
        if (sp == '0) begin
          ex_status = rpn_pkg::ST_UNDER;
        end else begin
          ex_sp = sp_m1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      rpn_pkg::S_IDLE: if (cmd.valid) state_next = rpn_pkg::S_TOP;
      rpn_pkg::S_TOP:  state_next = rpn_pkg::S_NXT;
      rpn_pkg::S_NXT:  state_next = rpn_pkg::S_EXEC;
      rpn_pkg::S_EXEC: state_next = ex_alu ? rpn_pkg::S_ALU : rpn_pkg::S_WB;
      rpn_pkg::S_ALU:  if (alu_done) state_next = rpn_pkg::S_WB;
      rpn_pkg::S_WB:   if (wb_go) state_next = rpn_pkg::S_IDLE;
      default:         state_next = rpn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready     = 1'b0;
    mem_raddr     = sp_m2[AW-1:0];
    mem_we        = 1'b0;
    alu_req.start = 1'b0;
    alu_req.div   = ex_div;
    case (state)
      rpn_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        mem_raddr = sp_m1[AW-1:0];
      end
      rpn_pkg::S_EXEC: alu_req.start = ex_alu;
      rpn_pkg::S_WB:   mem_we = wb_go && wr_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpn_pkg::S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wb_go) begin
        sp        <= nsp_q;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rpn_pkg::S_IDLE: begin
        func_q <= cmd.func;
        opnd_q <= cmd.operand;
      end
      rpn_pkg::S_TOP: r_q <= (sp == '0) ? '0 : mem_rdata;
      rpn_pkg::S_NXT: l_q <= mem_rdata;
      rpn_pkg::S_EXEC: begin
        wr_q     <= ex_wr;
        waddr_q  <= ex_addr;
        nsp_q    <= ex_sp;
        res_q    <= ex_res;
        status_q <= ex_status;
      end
      rpn_pkg::S_ALU: if (alu_done) res_q <= alu_result;
      default: begin
      end
    endcase
    if (wb_go) begin
      out_value  <= res_q;
      out_depth  <= nsp_q;
      out_status <= status_q;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.value     = out_value;
  assign rsp.depth     = out_depth;
  assign rsp.empty_res = (out_depth == '0);
  assign rsp.status    = out_status;

endmodule

`default_nettype wire

// ===== rtl/core/rpn_mem.sv =====
// ----------------------------------------------------------------------------
// rpn_mem
// Stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_mem #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]          wdata,
  input  logic [$clog2(STACK_DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]          rdata
);

  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpn_alu.sv =====
// ----------------------------------------------------------------------------
// rpn_alu
// Iterative multiply (shift-add, low half kept) and signed divide
// (restoring, truncating toward zero). One bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rpn_pkg::alu_req_t     req,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic                  busy;
  logic                  fin;
  logic [CW-1:0]         cnt;
  logic                  is_div;
  logic                  neg;
  logic [DATA_WIDTH-1:0] acc;   // product, or remainder when dividing
  logic [DATA_WIDTH-1:0] mc;    // multiplicand, or divisor magnitude
  logic [DATA_WIDTH-1:0] mp;    // multiplier, or dividend/quotient

  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;

  assign a_mag   = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
  assign b_mag   = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
  assign shifted = {acc, mp[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, mc};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(DATA_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.div;
      neg    <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
      acc    <= '0;
      if (req.div) begin
        mp <= a_mag;
        mc <= b_mag;
      end else begin
        mc <= a;
        mp <= b;
      end
    end else if (busy) begin
      if (is_div) begin
        mp  <= {mp[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
        acc <= diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
      end else begin
        if (mp[0]) begin
          acc <= acc + mc;
        end
        mc <= {mc[DATA_WIDTH-2:0], 1'b0};
        mp <= {1'b0, mp[DATA_WIDTH-1:1]};
      end
    end
  end

  assign done   = fin;
  assign result = is_div ? (neg ? (~mp + 1'b1) : mp) : acc;

endmodule

`default_nettype wire

// ===== rtl/core/rpn_checker.sv =====
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks on the RPN calculator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rpn_stack_calculator_macros.svh"

module rpn_checker #(
  parameter int STACK_DEPTH = 64
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             cmd_valid,
  input logic                             cmd_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic                             rsp_empty_res,
  input logic [$clog2(STACK_DEPTH+1)-1:0] rsp_depth,
  input logic [1:0]                       rsp_status
);

  localparam int DW = $clog2(STACK_DEPTH + 1);

  `RPN_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
  `RPN_ASSERT_NEXT(a_one_item, cmd_valid && cmd_ready, !cmd_ready, "second item taken while busy")
  `RPN_ASSERT_NOW(a_depth_max, rsp_valid, rsp_depth <= DW'(STACK_DEPTH), "depth above capacity")
  `RPN_ASSERT_NOW(a_empty, rsp_valid, rsp_empty_res == (rsp_depth == '0), "empty flag disagrees")
  `RPN_ASSERT_NOW(a_over_full, rsp_valid && (rsp_status == rpn_pkg::ST_OVER), rsp_depth == DW'(STACK_DEPTH), "overflow below capacity")

endmodule

bind rpn_stack_calculator rpn_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_rpn_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_empty_res (rsp.empty_res),
  .rsp_depth     (rsp.depth),
  .rsp_status    (rsp.status)
);

`default_nettype wire
